>>> rtl/assert_macros.svh
// Assertion macros used by the rank transform core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define RTDC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RTDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rtdc_pkg.sv
// ----------------------------------------------------------------------------
// rtdc_pkg
// Shared sizes for the rank transform core and its channel interfaces.
// ----------------------------------------------------------------------------
package rtdc_pkg;

  parameter int MAX_ELEMENTS = 64;
  parameter int VAL_W        = 32;
  parameter int POS_W        = 6;
  parameter int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  parameter int CNT_W        = $clog2(MAX_ELEMENTS + 1);

endpackage

>>> rtl/rtdc_ifs.sv
// ----------------------------------------------------------------------------
// rtdc_in_if / rtdc_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface rtdc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rtdc_pkg::VAL_W-1:0] value;
  logic                              final_req;

  modport source (output valid, value, final_req, input ready);
  modport sink   (input valid, value, final_req, output ready);
endinterface

interface rtdc_out_if;
  logic                       valid;
  logic                       ready;
  logic [rtdc_pkg::POS_W-1:0] position;
  logic [rtdc_pkg::POS_W-1:0] rank;
  logic                       has_duplicate;
  logic                       overflow;
  logic                       end_of_run;

  modport source (output valid, position, rank, has_duplicate, overflow, end_of_run,
                  input ready);
  modport sink   (input valid, position, rank, has_duplicate, overflow, end_of_run,
                  output ready);
endinterface

>>> rtl/rank_transform_with_duplicate_check_core.sv
// ----------------------------------------------------------------------------
// rank_transform_with_duplicate_check_core
// Collects a set of signed values, ranks each one by counting smaller values,
// flags duplicates and returns one result per stored position.
//
//   channel | dir | fields
//   --------+-----+----------------------------------------------------------
//   din     | in  | value[31:0] signed, final_req
//   dout    | out | position[5:0], rank[5:0], has_duplicate, overflow,
//           |     | end_of_run
//
// din takes items back to back while loading. A final item starts an n*n
// compare scan, one pair per cycle from the dual-read value store, then a
// drain state. Each result then passes through a rank memory read, a load
// into the output register and a handshake. din is held off from the final
// item until the last result is taken; a stalled dout simply holds. Reset is
// synchronous; memories are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rank_transform_with_duplicate_check_core (
  input  logic             clk,
  input  logic             rst,
  rtdc_in_if.sink          din,
  rtdc_out_if.source       dout
);

  typedef enum logic [2:0] {
    LOAD,
    SCAN,
    DRAIN,
    EMIT_RD,
    EMIT_LD,
    EMIT_WAIT
  } state_t;

  state_t state;

  logic signed [rtdc_pkg::VAL_W-1:0] value_store [rtdc_pkg::MAX_ELEMENTS];
  logic        [rtdc_pkg::IDX_W-1:0] rank_store  [rtdc_pkg::MAX_ELEMENTS];

  logic [rtdc_pkg::CNT_W-1:0] loaded_count;
  logic                       dropped;
  logic                       dup;
  logic [rtdc_pkg::IDX_W-1:0] idx_i;
  logic [rtdc_pkg::IDX_W-1:0] idx_j;
  logic [rtdc_pkg::IDX_W-1:0] pos;
  logic [rtdc_pkg::IDX_W-1:0] last_idx;
  logic                       full;

  logic signed [rtdc_pkg::VAL_W-1:0] rdata_a;
  logic signed [rtdc_pkg::VAL_W-1:0] rdata_b;
  logic                              cmp_valid;
  logic                              cmp_last;
  logic                              cmp_self;
  logic [rtdc_pkg::IDX_W-1:0]        cmp_i;
  logic [rtdc_pkg::IDX_W-1:0]        acc;
  logic [rtdc_pkg::IDX_W-1:0]        acc_next;
  logic                              lt;
  logic                              rank_we;
  logic [rtdc_pkg::IDX_W-1:0]        rank_rdata;

  logic                       in_acc;
  logic                       out_acc;
  logic                       out_valid;
  logic [rtdc_pkg::POS_W-1:0] out_position;
  logic [rtdc_pkg::POS_W-1:0] out_rank;
  logic                       out_dup;
  logic                       out_ovf;
  logic                       out_end;

  assign full     = (loaded_count == rtdc_pkg::CNT_W'(rtdc_pkg::MAX_ELEMENTS));
  assign last_idx = rtdc_pkg::IDX_W'(loaded_count - rtdc_pkg::CNT_W'(1));
  assign in_acc   = din.valid && din.ready;
  assign out_acc  = out_valid && dout.ready;
  assign din.ready = (state == LOAD);

  assign lt       = rdata_b < rdata_a;
  assign acc_next = acc + rtdc_pkg::IDX_W'(lt);
  assign rank_we  = cmp_valid && cmp_last;

  // value store: one write port, two read ports
  always_ff @(posedge clk) begin
    if (in_acc && !full) begin
      value_store[loaded_count[rtdc_pkg::IDX_W-1:0]] <= din.value;
    end
    rdata_a <= value_store[idx_i];
    rdata_b <= value_store[idx_j];
  end

  // rank store: one write port, one read port
  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_store[cmp_i] <= acc_next;
    end
    rank_rdata <= rank_store[pos];
  end

  // compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= (state == SCAN);
    end
    cmp_last <= (idx_j == last_idx);
    cmp_self <= (idx_j == idx_i);
    cmp_i    <= idx_i;
    if (state == LOAD) begin
      acc <= '0;
    end else if (cmp_valid) begin
      acc <= cmp_last ? '0 : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= LOAD;
      loaded_count <= '0;
      dropped      <= 1'b0;
      dup          <= 1'b0;
      idx_i        <= '0;
      idx_j        <= '0;
      pos          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmp_valid && !cmp_self && rdata_a == rdata_b) begin
        dup <= 1'b1;
      end
      case (state)
        LOAD: begin
          if (in_acc) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              loaded_count <= loaded_count + rtdc_pkg::CNT_W'(1);
            end
            if (din.final_req) begin
              idx_i <= '0;
              idx_j <= '0;
              dup   <= 1'b0;
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (idx_j == last_idx) begin
            idx_j <= '0;
            idx_i <= idx_i + rtdc_pkg::IDX_W'(1);
            if (idx_i == last_idx) begin
              state <= DRAIN;
            end
          end else begin
            idx_j <= idx_j + rtdc_pkg::IDX_W'(1);
          end
        end
        DRAIN: begin
          pos   <= '0;
          state <= EMIT_RD;
        end
        EMIT_RD: begin
          state <= EMIT_LD;
        end
        EMIT_LD: begin
          out_valid    <= 1'b1;
          out_position <= rtdc_pkg::POS_W'(pos);
          out_rank     <= rtdc_pkg::POS_W'(rank_rdata);
          out_dup      <= dup;
          out_ovf      <= dropped;
          out_end      <= (pos == last_idx);
          state        <= EMIT_WAIT;
        end
        EMIT_WAIT: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            if (out_end) begin
              loaded_count <= '0;
              dropped      <= 1'b0;
              state        <= LOAD;
            end else begin
              pos   <= pos + rtdc_pkg::IDX_W'(1);
              state <= EMIT_RD;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

  assign dout.valid         = out_valid;
  assign dout.position      = out_position;
  assign dout.rank          = out_rank;
  assign dout.has_duplicate = out_dup;
  assign dout.overflow      = out_ovf;
  assign dout.end_of_run    = out_end;

  `RTDC_ASSERT(a_no_overlap, clk, rst, !(din.ready && dout.valid), "load and emit overlap")
  `RTDC_ASSERT(a_count_bound, clk, rst, loaded_count <= rtdc_pkg::CNT_W'(rtdc_pkg::MAX_ELEMENTS), "count past depth")
  `RTDC_ASSERT(a_end_clears, clk, rst, (out_acc && out_end) |=> (din.ready && loaded_count == '0 && !dropped), "set not closed after last result")
  `RTDC_ASSERT(a_drop_when_full, clk, rst, $rose(dropped) |-> $past(full), "item dropped while store not full")

endmodule

>>> verif/tb_rank_transform_with_duplicate_check_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rank_transform_with_duplicate_check_core
// Loads sets of signed values into the rank core and checks every result
// (position, rank, duplicate flag, overflow, end marker) in load order. The
// expected results come from a counting predictor kept in step with each
// accepted item, or a fixed table for typed rows. Directed rows come first,
// then random sets of mostly small sizes plus one set that overruns the
// store. Both channels idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module tb_rank_transform_with_duplicate_check_core;

  localparam int QUIET_LIMIT = 20000;
  localparam int SEND_IDLE [4] = '{0, 77, 0, 34};
  localparam int RECV_STALL [4] = '{0, 0, 77, 34};

  typedef struct packed {
    logic signed [rtdc_pkg::VAL_W-1:0] value;
    logic                              final_req;
    logic                              typed;
  } load_row_t;

  typedef struct packed {
    logic [rtdc_pkg::POS_W-1:0] position;
    logic [rtdc_pkg::POS_W-1:0] rank;
    logic                       has_duplicate;
    logic                       overflow;
    logic                       end_of_run;
  } rank_result_t;

  localparam int DIRECTED_ROWS = 22;
  localparam load_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{32'sh80000000, 1'b1, 1'b1},
    '{32'sh7FFFFFFF, 1'b0, 1'b1},
    '{32'sh80000000, 1'b0, 1'b1},
    '{32'sh7FFFFFFF, 1'b1, 1'b1},
    '{32'sh00000000, 1'b0, 1'b1},
    '{32'shFFFFFFFF, 1'b0, 1'b1},
    '{32'sh00000001, 1'b1, 1'b1},
    '{32'sh55555555, 1'b0, 1'b0},
    '{32'shAAAAAAAA, 1'b0, 1'b0},
    '{32'sh7FFFFFFE, 1'b0, 1'b0},
    '{32'sh80000001, 1'b0, 1'b0},
    '{32'shFFFFFFFE, 1'b0, 1'b0},
    '{32'sh00000002, 1'b1, 1'b0},
    '{32'sh12345678, 1'b0, 1'b0},
    '{32'sh12345678, 1'b0, 1'b0},
    '{32'sh12345678, 1'b0, 1'b0},
    '{32'sh12345678, 1'b1, 1'b0},
    '{32'sh00000005, 1'b0, 1'b0},
    '{32'sh00000004, 1'b0, 1'b0},
    '{32'sh00000003, 1'b0, 1'b0},
    '{32'sh00000002, 1'b0, 1'b0},
    '{32'sh00000001, 1'b1, 1'b0}
  };

  // position, rank, has_duplicate, overflow, end_of_run
  localparam int TYPED_COUNT = 7;
  localparam rank_result_t TYPED_RESULTS [TYPED_COUNT] = '{
    '{6'd0, 6'd0, 1'b0, 1'b0, 1'b1},
    '{6'd0, 6'd1, 1'b1, 1'b0, 1'b0},
    '{6'd1, 6'd0, 1'b1, 1'b0, 1'b0},
    '{6'd2, 6'd1, 1'b1, 1'b0, 1'b1},
    '{6'd0, 6'd1, 1'b0, 1'b0, 1'b0},
    '{6'd1, 6'd0, 1'b0, 1'b0, 1'b0},
    '{6'd2, 6'd2, 1'b0, 1'b0, 1'b1}
  };

  logic clk;
  logic rst;

  rtdc_in_if  din_if ();
  rtdc_out_if dout_if ();

  rank_transform_with_duplicate_check_core uut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  logic signed [rtdc_pkg::VAL_W-1:0] shadow_vals [rtdc_pkg::MAX_ELEMENTS];
  int                                shadow_count;
  bit                                shadow_dropped;
  int                                typed_idx;
  rank_result_t                      pending_ranks [$];
  int                                mismatches;
  int                                quiet_cycles;
  int                                send_idle_pct;
  int                                recv_stall_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mirrors the load/rank behavior; queues one result per stored position on a final item.
  function automatic void rank_set_predict(input logic signed [rtdc_pkg::VAL_W-1:0] v,
                                           input logic fin, input bit typed);
    logic [rtdc_pkg::POS_W-1:0] ranks [rtdc_pkg::MAX_ELEMENTS];
    bit                         dup;
    rank_result_t               r;
    if (shadow_count < rtdc_pkg::MAX_ELEMENTS) begin
      shadow_vals[shadow_count] = v;
      shadow_count++;
    end else begin
      shadow_dropped = 1'b1;
    end
    if (!fin) return;
    dup = 1'b0;
    for (int j = 0; j < shadow_count; j++) begin
      ranks[j] = '0;
      for (int i = 0; i < shadow_count; i++) begin
        if (shadow_vals[i] < shadow_vals[j]) ranks[j] = ranks[j] + 1'b1;
        if (i != j && shadow_vals[i] == shadow_vals[j]) dup = 1'b1;
      end
    end
    for (int j = 0; j < shadow_count; j++) begin
      if (typed) begin
        r = TYPED_RESULTS[typed_idx];
        typed_idx++;
      end else begin
        r.position      = rtdc_pkg::POS_W'(j);
        r.rank          = ranks[j];
        r.has_duplicate = dup;
        r.overflow      = shadow_dropped;
        r.end_of_run    = (j == shadow_count - 1);
      end
      pending_ranks.push_back(r);
    end
    shadow_count   = 0;
    shadow_dropped = 1'b0;
  endfunction

  function automatic logic signed [rtdc_pkg::VAL_W-1:0] pick_value(
      input logic signed [rtdc_pkg::VAL_W-1:0] prev);
    case ($urandom_range(5))
      0:       return prev;
      1:       return $signed($urandom_range(8)) - 4;
      2:       return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic signed [rtdc_pkg::VAL_W-1:0] v, input logic fin,
                           input bit typed);
    while ($urandom_range(99) < send_idle_pct) begin
      din_if.valid <= 1'b0;
      @(posedge clk);
    end
    din_if.valid     <= 1'b1;
    din_if.value     <= v;
    din_if.final_req <= fin;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    rank_set_predict(v, fin, typed);
  endtask

  task automatic send_random_set(input int size);
    logic signed [rtdc_pkg::VAL_W-1:0] v;
    logic signed [rtdc_pkg::VAL_W-1:0] prev;
    prev = $urandom;
    for (int k = 0; k < size; k++) begin
      v = pick_value(prev);
      send_item(v, k == size - 1, 1'b0);
      prev = v;
    end
  endtask

  task automatic drain_results();
    din_if.valid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
  endtask

  // Result side: random stall, check against the oldest expectation, watchdog.
  always @(posedge clk) begin
    rank_result_t got;
    rank_result_t want;
    if (rst) begin
      dout_if.ready <= 1'b0;
      quiet_cycles  <= 0;
    end else begin
      if (dout_if.valid && dout_if.ready) begin
        got = '{dout_if.position, dout_if.rank, dout_if.has_duplicate,
                dout_if.overflow, dout_if.end_of_run};
        if (pending_ranks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: pos=%0d rank=%0d dup=%b ovf=%b eor=%b",
                     got.position, got.rank, got.has_duplicate, got.overflow,
                     got.end_of_run);
        end else begin
          want = pending_ranks.pop_front();
          if (got.position != want.position || got.rank != want.rank ||
              got.has_duplicate != want.has_duplicate ||
              got.overflow != want.overflow || got.end_of_run != want.end_of_run) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp pos=%0d rank=%0d dup=%b ovf=%b eor=%b, got pos=%0d rank=%0d dup=%b ovf=%b eor=%b",
                       want.position, want.rank, want.has_duplicate, want.overflow,
                       want.end_of_run, got.position, got.rank, got.has_duplicate,
                       got.overflow, got.end_of_run);
          end
        end
      end
      dout_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("tb_rank_transform_with_duplicate_check_core: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int sent;
    int sz;
    rst              <= 1'b1;
    din_if.valid     <= 1'b0;
    din_if.value     <= '0;
    din_if.final_req <= 1'b0;
    shadow_count     = 0;
    shadow_dropped   = 1'b0;
    typed_idx        = 0;
    mismatches       = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < DIRECTED_ROWS; n++)
      send_item(DIRECTED[n].value, DIRECTED[n].final_req, DIRECTED[n].typed);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      // one set that overruns the store, final item included among the dropped
      if (p == 0) send_random_set(rtdc_pkg::MAX_ELEMENTS + $urandom_range(1, 3));
      sent = 0;
      while (sent < 5) begin
        sz = $urandom_range(1, 6);
        send_random_set(sz);
        sent += sz;
      end
      drain_results();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_ranks.size() == 0) begin
      $display("tb_rank_transform_with_duplicate_check_core: clean");
    end else begin
      $display("tb_rank_transform_with_duplicate_check_core: errors");
    end
    $finish;
  end
endmodule
